### design/llsf_pkg.sv
// lane line fit package: shared types, register codes and reset values
// no dependencies
`default_nettype none

package llsf_pkg;

   localparam int COORD_W = 12;
   localparam int OUT_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int THR_W = 16;
   localparam int MAX_SEGMENTS_DEFAULT = 512;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM_ROW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_ROW = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE_THR = 2'd3;

   localparam logic [COORD_W-1:0] IMAGE_WIDTH_RESET = 12'd640;
   localparam logic [COORD_W-1:0] BOTTOM_ROW_RESET = 12'd480;
   localparam logic [COORD_W-1:0] TOP_ROW_RESET = 12'd288;
   localparam logic [THR_W-1:0] SLOPE_THR_RESET = 16'd128;

   localparam logic SIDE_RIGHT = 1'b0;
   localparam logic SIDE_LEFT = 1'b1;

   typedef struct packed {
      logic keep;
      logic side;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y1;
      logic [COORD_W-1:0] x2;
      logic [COORD_W-1:0] y2;
      logic last;
   } seg_entry_type;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } arith_op_type;

   typedef struct packed {
      logic start;
      arith_op_type op;
   } arith_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NXX,
      ST_SXSX,
      ST_NXY,
      ST_SXSY,
      ST_CHECK,
      ST_DEN,
      ST_SXP,
      ST_NROW,
      ST_QSXX,
      ST_DIV,
      ST_FINISH
   } back_state_type;

endpackage

`default_nettype wire

### design/llsf_if.sv
// segment and fit result channel interfaces
// depends on llsf_pkg
`default_nettype none

interface llsf_seg_if;
   logic valid;
   logic ready;
   logic segment_present;
   logic [llsf_pkg::COORD_W-1:0] start_x;
   logic [llsf_pkg::COORD_W-1:0] start_y;
   logic [llsf_pkg::COORD_W-1:0] end_x;
   logic [llsf_pkg::COORD_W-1:0] end_y;
   logic frame_last;
   modport source(output valid, segment_present, start_x, start_y, end_x, end_y, frame_last,
                  input ready);
   modport sink(input valid, segment_present, start_x, start_y, end_x, end_y, frame_last,
                output ready);
endinterface

interface llsf_fit_if;
   logic valid;
   logic ready;
   logic right_valid;
   logic signed [llsf_pkg::OUT_W-1:0] right_x_bottom;
   logic signed [llsf_pkg::OUT_W-1:0] right_x_top;
   logic left_valid;
   logic signed [llsf_pkg::OUT_W-1:0] left_x_bottom;
   logic signed [llsf_pkg::OUT_W-1:0] left_x_top;
   modport source(output valid, right_valid, right_x_bottom, right_x_top, left_valid,
                  left_x_bottom, left_x_top, input ready);
   modport sink(input valid, right_valid, right_x_bottom, right_x_top, left_valid,
                left_x_bottom, left_x_top, output ready);
endinterface

`default_nettype wire

### design/llsf_front.sv
// segment classifier: steepness test and side selection
// depends on llsf_pkg and llsf_if
`default_nettype none

module llsf_front (
   input  wire logic [llsf_pkg::COORD_W-1:0] image_width,
   input  wire logic [llsf_pkg::THR_W-1:0]   slope_thr,
   llsf_seg_if.sink                           req_chan,
   input  wire logic                          queue_ready,
   output logic                               queue_push,
   output llsf_pkg::seg_entry_type            queue_entry
);

   logic [llsf_pkg::COORD_W-1:0] adx;
   logic [llsf_pkg::COORD_W-1:0] ady;
   logic [llsf_pkg::COORD_W+llsf_pkg::THR_W-1:0] thr_dx;
   logic [llsf_pkg::COORD_W+llsf_pkg::THR_W-1:0] dy_q8;
   logic steep;
   logic pos;
   logic right;
   logic left;
   logic [llsf_pkg::COORD_W:0] cw;
   logic [llsf_pkg::COORD_W:0] x1_2;
   logic [llsf_pkg::COORD_W:0] x2_2;

   always_comb begin
      adx = (req_chan.end_x >= req_chan.start_x) ? req_chan.end_x - req_chan.start_x
                                                 : req_chan.start_x - req_chan.end_x;
      ady = (req_chan.end_y >= req_chan.start_y) ? req_chan.end_y - req_chan.start_y
                                                 : req_chan.start_y - req_chan.end_y;
      thr_dx = (llsf_pkg::COORD_W+llsf_pkg::THR_W)'(slope_thr) *
               (llsf_pkg::COORD_W+llsf_pkg::THR_W)'(adx);
      dy_q8 = {(llsf_pkg::THR_W-8)'(0), ady, 8'd0};
      steep = (adx == '0) || (dy_q8 > thr_dx);
      pos = (adx == '0) ||
            ((req_chan.end_x > req_chan.start_x) == (req_chan.end_y > req_chan.start_y));
      cw = {1'b0, image_width};
      x1_2 = {req_chan.start_x, 1'b0};
      x2_2 = {req_chan.end_x, 1'b0};
      right = pos && (x1_2 > cw) && (x2_2 > cw);
      left = !pos && (x1_2 < cw) && (x2_2 < cw);
      queue_entry.keep = req_chan.segment_present && steep && (right || left);
      queue_entry.side = right ? llsf_pkg::SIDE_RIGHT : llsf_pkg::SIDE_LEFT;
      queue_entry.x1 = req_chan.start_x;
      queue_entry.y1 = req_chan.start_y;
      queue_entry.x2 = req_chan.end_x;
      queue_entry.y2 = req_chan.end_y;
      queue_entry.last = req_chan.frame_last;
   end

   assign req_chan.ready = queue_ready;
   assign queue_push = req_chan.valid && queue_ready;

endmodule

`default_nettype wire

### design/llsf_queue.sv
// short fifo of classified segments between front and back
// depends on llsf_pkg
`default_nettype none

module llsf_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire llsf_pkg::seg_entry_type push_entry,
   output logic                         push_ready,
   input  wire logic                    pop,
   output logic                         pop_valid,
   output llsf_pkg::seg_entry_type      pop_entry
);

   localparam int PTR_W = $clog2(llsf_pkg::QUEUE_DEPTH);

   llsf_pkg::seg_entry_type mem_ff [llsf_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign push_ready = count_ff != (PTR_W+1)'(llsf_pkg::QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_entry = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

### design/llsf_arith.sv
// shared bit-serial signed multiplier and truncating divider, one bit a cycle
// depends on llsf_pkg
`default_nettype none

module llsf_arith #(
   parameter int NUM_W = 73
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire llsf_pkg::arith_ctl_type ctl,
   input  wire logic [NUM_W-1:0]        opa,
   input  wire logic [NUM_W-1:0]        opb,
   output logic                         done,
   output logic [NUM_W-1:0]             result
);

   localparam int CNT_W = $clog2(NUM_W);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   llsf_pkg::arith_op_type op_ff, op_in;
   logic neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] x_ff, x_in;
   logic [NUM_W-1:0] y_ff, y_in;
   logic [NUM_W-1:0] z_ff, z_in;
   logic [NUM_W-1:0] trial;
   logic ge;
   logic last_step;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in = op_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      trial = {x_ff[NUM_W-2:0], y_ff[NUM_W-1]};
      ge = trial >= z_ff;
      last_step = cnt_ff == CNT_W'(NUM_W-1);
      if (ctl.start) begin
         busy_in = 1'b1;
         op_in = ctl.op;
         cnt_in = '0;
         x_in = '0;
         if (ctl.op == llsf_pkg::OP_MUL) begin
            y_in = opb;
            z_in = opa;
            neg_in = 1'b0;
         end else begin
            y_in = opa[NUM_W-1] ? -opa : opa;
            z_in = opb[NUM_W-1] ? -opb : opb;
            neg_in = opa[NUM_W-1] ^ opb[NUM_W-1];
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (op_ff == llsf_pkg::OP_MUL) begin
            if (z_ff[0]) begin
               x_in = last_step ? x_ff - y_ff : x_ff + y_ff;
            end
            y_in = {y_ff[NUM_W-2:0], 1'b0};
            z_in = {1'b0, z_ff[NUM_W-1:1]};
         end else begin
            x_in = ge ? trial - z_ff : trial;
            y_in = {y_ff[NUM_W-2:0], ge};
         end
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done = done_ff;
   assign result = (op_ff == llsf_pkg::OP_MUL) ? x_ff : (neg_ff ? -y_ff : y_ff);

endmodule

`default_nettype wire

### design/llsf_back.sv
// per-side sum accumulation and frame-end fit sequencer with result register
// depends on llsf_pkg, llsf_if and llsf_arith
`default_nettype none

module llsf_back #(
   parameter int MAX_SEGMENTS_PER_SIDE = llsf_pkg::MAX_SEGMENTS_DEFAULT,
   parameter int CNT_W = 11,
   parameter int NUM_W = 73
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [llsf_pkg::COORD_W-1:0] bottom_row,
   input  wire logic [llsf_pkg::COORD_W-1:0] top_row,
   input  wire logic                         q_valid,
   input  wire llsf_pkg::seg_entry_type      q_entry,
   output logic                              q_pop,
   llsf_fit_if.source                        rsp_chan
);

   localparam int SX_W = CNT_W + llsf_pkg::COORD_W;
   localparam int SQ_W = CNT_W + 2*llsf_pkg::COORD_W;
   localparam int PR_W = 2*llsf_pkg::COORD_W;
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(2*MAX_SEGMENTS_PER_SIDE);
   localparam logic signed [NUM_W-1:0] SAT_HI = NUM_W'(32767);
   localparam logic signed [NUM_W-1:0] SAT_LO = -NUM_W'(32768);

   logic [CNT_W-1:0] cnt_ff [2];
   logic [SX_W-1:0] sx_ff [2];
   logic [SX_W-1:0] sy_ff [2];
   logic [SQ_W-1:0] sxx_acc_ff [2];
   logic [SQ_W-1:0] sxy_acc_ff [2];

   llsf_pkg::back_state_type state_ff, state_in;
   logic side_ff, side_in;
   logic row_ff, row_in;
   logic busy_ff, busy_in;
   logic out_valid_ff, out_valid_in;
   logic clear;
   logic [NUM_W-1:0] t_ff, t_in;
   logic [NUM_W-1:0] sxx_ff, sxx_in;
   logic [NUM_W-1:0] sxy_ff, sxy_in;
   logic [NUM_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] p_ff, p_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic res_valid_ff [2];
   logic signed [llsf_pkg::OUT_W-1:0] res_x_ff [2][2];
   logic res_valid_we;
   logic res_valid_val;
   logic res_x_we;
   logic signed [llsf_pkg::OUT_W-1:0] res_x_val;

   llsf_pkg::arith_ctl_type arith_ctl;
   logic [NUM_W-1:0] opa;
   logic [NUM_W-1:0] opb;
   logic arith_done;
   logic [NUM_W-1:0] arith_result;

   logic [NUM_W-1:0] n_cur;
   logic [NUM_W-1:0] sx_cur;
   logic [NUM_W-1:0] sy_cur;
   logic [NUM_W-1:0] row_cur;
   logic op_state;
   logic add_pt;
   logic [PR_W:0] xx_add;
   logic [PR_W:0] xy_add;
   logic [llsf_pkg::COORD_W:0] x_add;
   logic [llsf_pkg::COORD_W:0] y_add;

   llsf_arith #(
      .NUM_W(NUM_W)
   ) u_arith (
      .clock(clock),
      .reset(reset),
      .ctl(arith_ctl),
      .opa(opa),
      .opb(opb),
      .done(arith_done),
      .result(arith_result)
   );

   // accumulation of both endpoints of a popped segment
   always_comb begin
      q_pop = (state_ff == llsf_pkg::ST_IDLE) && q_valid && !(q_entry.last && out_valid_ff);
      add_pt = q_pop && q_entry.keep;
      x_add = (llsf_pkg::COORD_W+1)'(q_entry.x1) + (llsf_pkg::COORD_W+1)'(q_entry.x2);
      y_add = (llsf_pkg::COORD_W+1)'(q_entry.y1) + (llsf_pkg::COORD_W+1)'(q_entry.y2);
      xx_add = (PR_W+1)'(PR_W'(q_entry.x1) * PR_W'(q_entry.x1)) +
               (PR_W+1)'(PR_W'(q_entry.x2) * PR_W'(q_entry.x2));
      xy_add = (PR_W+1)'(PR_W'(q_entry.x1) * PR_W'(q_entry.y1)) +
               (PR_W+1)'(PR_W'(q_entry.x2) * PR_W'(q_entry.y2));
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < 2; s++) begin
         if (reset || clear) begin
            cnt_ff[s] <= '0;
            sx_ff[s] <= '0;
            sy_ff[s] <= '0;
            sxx_acc_ff[s] <= '0;
            sxy_acc_ff[s] <= '0;
         end else if (add_pt && (q_entry.side == 1'(s)) && (cnt_ff[s] < CNT_LIMIT)) begin
            cnt_ff[s] <= cnt_ff[s] + CNT_W'(2);
            sx_ff[s] <= sx_ff[s] + SX_W'(x_add);
            sy_ff[s] <= sy_ff[s] + SX_W'(y_add);
            sxx_acc_ff[s] <= sxx_acc_ff[s] + SQ_W'(xx_add);
            sxy_acc_ff[s] <= sxy_acc_ff[s] + SQ_W'(xy_add);
         end
      end
   end

   // fit sequencer
   always_comb begin
      n_cur = NUM_W'(side_ff ? cnt_ff[1] : cnt_ff[0]);
      sx_cur = NUM_W'(side_ff ? sx_ff[1] : sx_ff[0]);
      sy_cur = NUM_W'(side_ff ? sy_ff[1] : sy_ff[0]);
      row_cur = NUM_W'(row_ff ? top_row : bottom_row);

      state_in = state_ff;
      side_in = side_ff;
      row_in = row_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      clear = 1'b0;
      t_in = t_ff;
      sxx_in = sxx_ff;
      sxy_in = sxy_ff;
      den_in = den_ff;
      p_in = p_ff;
      num_in = num_ff;
      res_valid_we = 1'b0;
      res_valid_val = 1'b0;
      res_x_we = 1'b0;
      res_x_val = '0;
      opa = '0;
      opb = '0;
      op_state = 1'b1;
      arith_ctl.op = llsf_pkg::OP_MUL;

      unique case (state_ff)
         llsf_pkg::ST_IDLE: begin
            op_state = 1'b0;
            if (q_pop && q_entry.last) begin
               side_in = llsf_pkg::SIDE_RIGHT;
               state_in = llsf_pkg::ST_NXX;
            end
         end
         llsf_pkg::ST_NXX: begin
            opa = n_cur;
            opb = NUM_W'(side_ff ? sxx_acc_ff[1] : sxx_acc_ff[0]);
            if (arith_done) begin
               t_in = arith_result;
               state_in = llsf_pkg::ST_SXSX;
            end
         end
         llsf_pkg::ST_SXSX: begin
            opa = sx_cur;
            opb = sx_cur;
            if (arith_done) begin
               sxx_in = t_ff - arith_result;
               state_in = llsf_pkg::ST_NXY;
            end
         end
         llsf_pkg::ST_NXY: begin
            opa = n_cur;
            opb = NUM_W'(side_ff ? sxy_acc_ff[1] : sxy_acc_ff[0]);
            if (arith_done) begin
               t_in = arith_result;
               state_in = llsf_pkg::ST_SXSY;
            end
         end
         llsf_pkg::ST_SXSY: begin
            opa = sx_cur;
            opb = sy_cur;
            if (arith_done) begin
               sxy_in = t_ff - arith_result;
               row_in = 1'b0;
               state_in = llsf_pkg::ST_CHECK;
            end
         end
         llsf_pkg::ST_CHECK: begin
            op_state = 1'b0;
            row_in = 1'b0;
            res_valid_we = 1'b1;
            if (n_cur == '0 || sxx_ff == '0 || sxy_ff == '0) begin
               res_valid_val = 1'b0;
               res_x_we = 1'b1;
               res_x_val = '0;
               // empty or degenerate side: both columns read zero
               row_in = 1'b1;
               state_in = llsf_pkg::ST_CHECK;
               if (row_ff) begin
                  row_in = 1'b0;
                  if (side_ff == llsf_pkg::SIDE_LEFT) begin
                     state_in = llsf_pkg::ST_FINISH;
                  end else begin
                     side_in = llsf_pkg::SIDE_LEFT;
                     state_in = llsf_pkg::ST_NXX;
                  end
               end
            end else begin
               res_valid_val = 1'b1;
               state_in = llsf_pkg::ST_DEN;
            end
         end
         llsf_pkg::ST_DEN: begin
            opa = n_cur;
            opb = sxy_ff;
            if (arith_done) begin
               den_in = arith_result;
               state_in = llsf_pkg::ST_SXP;
            end
         end
         llsf_pkg::ST_SXP: begin
            opa = sx_cur;
            opb = sxy_ff;
            if (arith_done) begin
               p_in = arith_result;
               state_in = llsf_pkg::ST_NROW;
            end
         end
         llsf_pkg::ST_NROW: begin
            opa = n_cur;
            opb = row_cur;
            if (arith_done) begin
               t_in = arith_result;
               state_in = llsf_pkg::ST_QSXX;
            end
         end
         llsf_pkg::ST_QSXX: begin
            opa = t_ff - sy_cur;
            opb = sxx_ff;
            if (arith_done) begin
               num_in = p_ff + arith_result;
               state_in = llsf_pkg::ST_DIV;
            end
         end
         llsf_pkg::ST_DIV: begin
            arith_ctl.op = llsf_pkg::OP_DIV;
            opa = num_ff;
            opb = den_ff;
            if (arith_done) begin
               res_x_we = 1'b1;
               if ($signed(arith_result) > SAT_HI) begin
                  res_x_val = llsf_pkg::OUT_W'(SAT_HI);
               end else if ($signed(arith_result) < SAT_LO) begin
                  res_x_val = llsf_pkg::OUT_W'(SAT_LO);
               end else begin
                  res_x_val = arith_result[llsf_pkg::OUT_W-1:0];
               end
               if (!row_ff) begin
                  row_in = 1'b1;
                  state_in = llsf_pkg::ST_NROW;
               end else if (side_ff == llsf_pkg::SIDE_LEFT) begin
                  state_in = llsf_pkg::ST_FINISH;
               end else begin
                  side_in = llsf_pkg::SIDE_LEFT;
                  state_in = llsf_pkg::ST_NXX;
               end
            end
         end
         llsf_pkg::ST_FINISH: begin
            op_state = 1'b0;
            clear = 1'b1;
            out_valid_in = 1'b1;
            state_in = llsf_pkg::ST_IDLE;
         end
         default: begin
            op_state = 1'b0;
            state_in = llsf_pkg::ST_IDLE;
         end
      endcase

      arith_ctl.start = op_state && !busy_ff;
      busy_in = arith_ctl.start ? 1'b1 : (arith_done ? 1'b0 : busy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= llsf_pkg::ST_IDLE;
         busy_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= side_in;
      row_ff <= row_in;
      t_ff <= t_in;
      sxx_ff <= sxx_in;
      sxy_ff <= sxy_in;
      den_ff <= den_in;
      p_ff <= p_in;
      num_ff <= num_in;
      if (res_valid_we) begin
         res_valid_ff[side_ff] <= res_valid_val;
      end
      if (res_x_we) begin
         res_x_ff[side_ff][row_ff] <= res_x_val;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.right_valid = res_valid_ff[0];
   assign rsp_chan.right_x_bottom = res_x_ff[0][0];
   assign rsp_chan.right_x_top = res_x_ff[0][1];
   assign rsp_chan.left_valid = res_valid_ff[1];
   assign rsp_chan.left_x_bottom = res_x_ff[1][0];
   assign rsp_chan.left_x_top = res_x_ff[1][1];

endmodule

`default_nettype wire

### design/lane_line_least_squares_fit.sv
// Lane line least-squares fit. Segments are classified and queued at one per cycle while
// the queue has room, and summed per side at one per cycle while the back is idle; a
// frame_last item then runs an exact integer fit on a shared bit-serial multiply/divide
// unit (NUM_W = 3*CNT_W+40, 73 at the default side bound): 12 operations per fitted side;
// an empty or degenerate side takes 4 operations. Input keeps flowing into the four-entry
// queue during a fit and while a result waits; a further frame end waits for the result
// to be taken.
// top level: configuration registers and the front, queue and back parts
// depends on llsf_pkg, llsf_if, llsf_front, llsf_queue and llsf_back
`default_nettype none

module lane_line_least_squares_fit #(
   parameter int MAX_SEGMENTS_PER_SIDE = llsf_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [llsf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [llsf_pkg::CSR_DATA_W-1:0] csr_write_data,
   llsf_seg_if.sink                             req_chan,
   llsf_fit_if.source                           rsp_chan
);

   localparam int CNT_W = $clog2(2*MAX_SEGMENTS_PER_SIDE + 2);
   localparam int NUM_W = 3*CNT_W + 40;

   logic [llsf_pkg::COORD_W-1:0] image_width_ff;
   logic [llsf_pkg::COORD_W-1:0] bottom_row_ff;
   logic [llsf_pkg::COORD_W-1:0] top_row_ff;
   logic [llsf_pkg::THR_W-1:0] slope_thr_ff;

   logic queue_ready;
   logic queue_push;
   llsf_pkg::seg_entry_type queue_in;
   logic queue_pop;
   logic queue_valid;
   llsf_pkg::seg_entry_type queue_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= llsf_pkg::IMAGE_WIDTH_RESET;
         bottom_row_ff <= llsf_pkg::BOTTOM_ROW_RESET;
         top_row_ff <= llsf_pkg::TOP_ROW_RESET;
         slope_thr_ff <= llsf_pkg::SLOPE_THR_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            llsf_pkg::CSR_IMAGE_WIDTH:
               image_width_ff <= csr_write_data[llsf_pkg::COORD_W-1:0];
            llsf_pkg::CSR_BOTTOM_ROW:
               bottom_row_ff <= csr_write_data[llsf_pkg::COORD_W-1:0];
            llsf_pkg::CSR_TOP_ROW:
               top_row_ff <= csr_write_data[llsf_pkg::COORD_W-1:0];
            llsf_pkg::CSR_SLOPE_THR:
               slope_thr_ff <= csr_write_data[llsf_pkg::THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   llsf_front u_front (
      .image_width(image_width_ff),
      .slope_thr(slope_thr_ff),
      .req_chan(req_chan),
      .queue_ready(queue_ready),
      .queue_push(queue_push),
      .queue_entry(queue_in)
   );

   llsf_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(queue_push),
      .push_entry(queue_in),
      .push_ready(queue_ready),
      .pop(queue_pop),
      .pop_valid(queue_valid),
      .pop_entry(queue_out)
   );

   llsf_back #(
      .MAX_SEGMENTS_PER_SIDE(MAX_SEGMENTS_PER_SIDE),
      .CNT_W(CNT_W),
      .NUM_W(NUM_W)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .bottom_row(bottom_row_ff),
      .top_row(top_row_ff),
      .q_valid(queue_valid),
      .q_entry(queue_out),
      .q_pop(queue_pop),
      .rsp_chan(rsp_chan)
   );

endmodule

`default_nettype wire

### design/llsf_checker.sv
// port-level checks for the lane line fit, bound to the top level
// depends on llsf_pkg and lane_line_least_squares_fit
`default_nettype none

module llsf_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic                               right_valid,
   input wire logic signed [llsf_pkg::OUT_W-1:0]  right_x_bottom,
   input wire logic signed [llsf_pkg::OUT_W-1:0]  right_x_top,
   input wire logic                               left_valid,
   input wire logic signed [llsf_pkg::OUT_W-1:0]  left_x_bottom,
   input wire logic signed [llsf_pkg::OUT_W-1:0]  left_x_top
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(right_x_bottom) && $stable(left_x_bottom) &&
         $stable(right_x_top) && $stable(left_x_top))
      else $error("result changed while stalled");

   a_right_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !right_valid |-> right_x_bottom == 0 && right_x_top == 0)
      else $error("invalid right line with nonzero column");

   a_left_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !left_valid |-> left_x_bottom == 0 && left_x_top == 0)
      else $error("invalid left line with nonzero column");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

endmodule

bind lane_line_least_squares_fit llsf_checker u_llsf_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .right_valid(rsp_chan.right_valid),
   .right_x_bottom(rsp_chan.right_x_bottom),
   .right_x_top(rsp_chan.right_x_top),
   .left_valid(rsp_chan.left_valid),
   .left_x_bottom(rsp_chan.left_x_bottom),
   .left_x_top(rsp_chan.left_x_top)
);

`default_nettype wire

### tb/lane_line_least_squares_fit_test.sv
// testbench for the lane line least-squares fit: directed table then random frames
// checked against an exact integer fit predictor; depends on llsf_pkg, llsf_if and lane_line_least_squares_fit
`default_nettype none

module lane_line_least_squares_fit_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      bit present;
      bit [11:0] x1, y1, x2, y2;
      bit last;
   } segment_type;

   typedef struct {
      bit rv;
      logic signed [15:0] rb, rt;
      bit lv;
      logic signed [15:0] lb, lt;
   } lane_fit_type;

   typedef struct {
      segment_type seg;
      bit typed;
      lane_fit_type fit;
   } table_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [llsf_pkg::CSR_IDX_W-1:0] csr_index;
   logic [llsf_pkg::CSR_DATA_W-1:0] csr_write_data;

   llsf_seg_if seg ();
   llsf_fit_if fit ();

   lane_line_least_squares_fit DUT (
      .clock(clock), .reset(reset), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data),
      .req_chan(seg), .rsp_chan(fit)
   );

   bit [11:0] width_cfg, bottom_cfg, top_cfg;
   bit [15:0] thr_cfg;
   longint n_pts[2], sum_x[2], sum_y[2], sum_xx[2], sum_xy[2];
   lane_fit_type expected_fits[$];
   int mismatches = 0;
   int fits_seen = 0;
   int burst_left = 0;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #250ms;
      $display("Mismatches found");
      $finish;
   end

   task automatic report(string what, longint got, longint want);
      $display("mismatch on fit %0d, %s: got %0d, expected %0d", fits_seen, what, got, want);
      mismatches++;
   endtask

   function automatic logic signed [15:0] column_at(int s, bit [11:0] row,
                                                    longint vxx, longint vxy);
      logic signed [127:0] num, den, q;
      logic signed [127:0] a, b;
      a = 128'(sum_x[s]);
      b = 128'(vxy);
      num = a * b;
      a = 128'(n_pts[s] * longint'(row) - sum_y[s]);
      b = 128'(vxx);
      num = num + a * b;
      a = 128'(n_pts[s]);
      b = 128'(vxy);
      den = a * b;
      q = num / den;
      if (q > 32767) return 16'sd32767;
      if (q < -32768) return 16'sh8000;
      return q[15:0];
   endfunction

   task automatic fit_side(int s, output bit ok, output logic signed [15:0] xb, xt);
      longint vxx, vxy;
      ok = 0;
      xb = 0;
      xt = 0;
      if (n_pts[s] == 0) return;
      vxx = n_pts[s] * sum_xx[s] - sum_x[s] * sum_x[s];
      vxy = n_pts[s] * sum_xy[s] - sum_x[s] * sum_y[s];
      if (vxx == 0 || vxy == 0) return;
      ok = 1;
      xb = column_at(s, bottom_cfg, vxx, vxy);
      xt = column_at(s, top_cfg, vxx, vxy);
   endtask

   task automatic accumulate(segment_type g, output bit done, output lane_fit_type f);
      longint adx, ady;
      bit keep, pos;
      int s;
      done = 0;
      if (g.present) begin
         adx = g.x2 >= g.x1 ? g.x2 - g.x1 : g.x1 - g.x2;
         ady = g.y2 >= g.y1 ? g.y2 - g.y1 : g.y1 - g.y2;
         if (adx == 0) begin
            keep = 1;
            pos = 1;
         end else begin
            keep = ady * 256 > longint'(thr_cfg) * adx;
            pos = (g.x2 > g.x1) == (g.y2 > g.y1);
         end
         s = -1;
         if (keep && pos && 2 * g.x1 > width_cfg && 2 * g.x2 > width_cfg) s = 0;
         else if (keep && !pos && 2 * g.x1 < width_cfg && 2 * g.x2 < width_cfg) s = 1;
         if (s >= 0 && n_pts[s] < 2 * llsf_pkg::MAX_SEGMENTS_DEFAULT) begin
            n_pts[s] += 2;
            sum_x[s] += g.x1 + g.x2;
            sum_y[s] += g.y1 + g.y2;
            sum_xx[s] += longint'(g.x1) * g.x1 + longint'(g.x2) * g.x2;
            sum_xy[s] += longint'(g.x1) * g.y1 + longint'(g.x2) * g.y2;
         end
      end
      if (g.last) begin
         fit_side(0, f.rv, f.rb, f.rt);
         fit_side(1, f.lv, f.lb, f.lt);
         done = 1;
         for (int i = 0; i < 2; i++) begin
            n_pts[i] = 0; sum_x[i] = 0; sum_y[i] = 0; sum_xx[i] = 0; sum_xy[i] = 0;
         end
      end
   endtask

   // one transfer on the segment channel, with burst gaps in front
   task automatic offer(segment_type g, bit typed = 0, lane_fit_type want = '{default: 0});
      bit done;
      lane_fit_type f;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 2) != 0) begin
            @(negedge clock);
            seg.valid = 0;
            repeat ($urandom_range(0, 8)) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      seg.valid = 1;
      seg.segment_present = g.present;
      seg.start_x = g.x1;
      seg.start_y = g.y1;
      seg.end_x = g.x2;
      seg.end_y = g.y2;
      seg.frame_last = g.last;
      do @(posedge clock); while (!seg.ready);
      accumulate(g, done, f);
      if (done) expected_fits.insert(expected_fits.size(), typed ? want : f);
   endtask

   task automatic settle();
      @(negedge clock);
      seg.valid = 0;
      while (expected_fits.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic csr_write(bit [llsf_pkg::CSR_IDX_W-1:0] idx, bit [15:0] data);
      @(negedge clock);
      csr_write_enable = 1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 0;
      case (idx)
         llsf_pkg::CSR_IMAGE_WIDTH: width_cfg = data[11:0];
         llsf_pkg::CSR_BOTTOM_ROW: bottom_cfg = data[11:0];
         llsf_pkg::CSR_TOP_ROW: top_cfg = data[11:0];
         llsf_pkg::CSR_SLOPE_THR: thr_cfg = data;
         default: ;
      endcase
   endtask

   function automatic segment_type lane_segment(bit right);
      segment_type g;
      int lo, hi;
      bit [11:0] t;
      g.present = 1;
      g.last = 0;
      g.y1 = 12'($urandom_range(0, 4095));
      g.y2 = 12'($urandom_range(0, 4095));
      lo = width_cfg / 2 + 1;
      hi = (int'(width_cfg) - 1) / 2;
      if (right && lo <= 4095) begin
         g.x1 = 12'($urandom_range(lo, 4095));
         g.x2 = 12'($urandom_range(lo, 4095));
      end else if (!right && width_cfg != 0) begin
         g.x1 = 12'($urandom_range(0, hi));
         g.x2 = 12'($urandom_range(0, hi));
      end else begin
         g.x1 = 12'($urandom_range(0, 4095));
         g.x2 = 12'($urandom_range(0, 4095));
      end
      if (((g.x2 > g.x1) == (g.y2 > g.y1)) != right) begin
         t = g.y1; g.y1 = g.y2; g.y2 = t;
      end
      return g;
   endfunction

   task automatic random_frames(int count);
      segment_type g;
      int len;
      while (count > 0) begin
         len = $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 4) == 0) begin
               g.present = 1'($urandom_range(0, 1));
               g.x1 = 12'($urandom); g.y1 = 12'($urandom);
               g.x2 = 12'($urandom); g.y2 = 12'($urandom);
            end else begin
               g = lane_segment(1'($urandom_range(0, 1)));
            end
            g.last = (i == len - 1);
            offer(g);
            count--;
         end
      end
   endtask

   // receiver: stall patterns picked at random, and one long hold-off after the eighth fit
   initial begin
      int mode, cyc, hold_left;
      bit held;
      mode = 0;
      cyc = 0;
      held = 0;
      hold_left = 0;
      fit.ready = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 300 == 0) mode = $urandom_range(0, 3);
         if (!held && fits_seen == 8) begin
            held = 1;
            hold_left = 3000;
         end
         if (hold_left > 0) begin
            hold_left--;
            fit.ready = 0;
         end else case (mode)
            0: fit.ready = 1;
            1: fit.ready = (cyc % 5) < 3;
            2: fit.ready = $urandom_range(0, 3) == 0;
            default: fit.ready = (cyc % 40) >= 25;
         endcase
      end
   end

   always @(posedge clock) begin
      lane_fit_type w;
      if (!reset && fit.valid && fit.ready) begin
         fits_seen++;
         if (expected_fits.size() == 0) begin
            report("unexpected transfer", 1, 0);
         end else begin
            w = expected_fits.pop_front();
            if (fit.right_valid !== w.rv) report("right_valid", fit.right_valid, w.rv);
            if (fit.right_x_bottom !== w.rb) report("right_x_bottom", fit.right_x_bottom, w.rb);
            if (fit.right_x_top !== w.rt) report("right_x_top", fit.right_x_top, w.rt);
            if (fit.left_valid !== w.lv) report("left_valid", fit.left_valid, w.lv);
            if (fit.left_x_bottom !== w.lb) report("left_x_bottom", fit.left_x_bottom, w.lb);
            if (fit.left_x_top !== w.lt) report("left_x_top", fit.left_x_top, w.lt);
         end
      end
   end

   initial begin
      table_row_type rows[$];
      lane_fit_type none;
      segment_type g;
      none = '{default: 0};
      seg.valid = 0;
      seg.segment_present = 0;
      seg.start_x = 0; seg.start_y = 0; seg.end_x = 0; seg.end_y = 0;
      seg.frame_last = 0;
      csr_write_enable = 0;
      csr_index = llsf_pkg::CSR_IMAGE_WIDTH;
      csr_write_data = 0;
      width_cfg = llsf_pkg::IMAGE_WIDTH_RESET;
      bottom_cfg = llsf_pkg::BOTTOM_ROW_RESET;
      top_cfg = llsf_pkg::TOP_ROW_RESET;
      thr_cfg = llsf_pkg::SLOPE_THR_RESET;
      for (int i = 0; i < 2; i++) begin
         n_pts[i] = 0; sum_x[i] = 0; sum_y[i] = 0; sum_xx[i] = 0; sum_xy[i] = 0;
      end
      reset = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      rows = '{
         '{'{0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1}, 1, none},
         '{'{1, 400, 300, 400, 400, 1}, 1, none},
         '{'{1, 100, 300, 300, 300, 1}, 1, none},
         '{'{0, 12'hFFF, 0, 0, 12'hFFF, 0}, 0, none},
         '{'{1, 400, 300, 450, 400, 0}, 0, none},
         '{'{1, 500, 400, 560, 470, 1}, 0, none},
         '{'{1, 200, 300, 150, 400, 0}, 0, none},
         '{'{1, 100, 450, 20, 470, 1}, 0, none},
         '{'{1, 4095, 4095, 4000, 0, 0}, 0, none},
         '{'{1, 321, 0, 4095, 4095, 0}, 0, none},
         '{'{1, 0, 4095, 319, 0, 0}, 0, none},
         '{'{1, 0, 4000, 2, 0, 0}, 0, none},
         '{'{1, 330, 300, 331, 4095, 0}, 0, none},
         '{'{1, 320, 100, 330, 300, 0}, 0, none},
         '{'{1, 5, 100, 300, 120, 1}, 0, none},
         '{'{1, 700, 10, 700, 20, 0}, 0, none},
         '{'{1, 701, 4095, 702, 0, 1}, 0, none}
      };
      foreach (rows[i]) offer(rows[i].seg, rows[i].typed, rows[i].fit);
      random_frames(40);

      // one side over its segment bound: vertical segments right of centre are all kept
      for (int i = 0; i < 514; i++) begin
         g = lane_segment(1);
         g.x2 = g.x1;
         g.last = (i == 513);
         offer(g);
      end
      settle();

      csr_write(llsf_pkg::CSR_IMAGE_WIDTH, 16'hFFFF);
      csr_write(llsf_pkg::CSR_BOTTOM_ROW, 16'd4095);
      csr_write(llsf_pkg::CSR_TOP_ROW, 16'd0);
      csr_write(llsf_pkg::CSR_SLOPE_THR, 16'hFFFF);
      random_frames(12);
      settle();
      csr_write(llsf_pkg::CSR_IMAGE_WIDTH, 16'd0);
      csr_write(llsf_pkg::CSR_BOTTOM_ROW, 16'd0);
      csr_write(llsf_pkg::CSR_TOP_ROW, 16'd4095);
      csr_write(llsf_pkg::CSR_SLOPE_THR, 16'd0);
      random_frames(12);
      settle();
      csr_write(llsf_pkg::CSR_IMAGE_WIDTH, 16'hF001);
      csr_write(llsf_pkg::CSR_BOTTOM_ROW, 16'hA800);
      csr_write(llsf_pkg::CSR_TOP_ROW, 16'd1000);
      csr_write(llsf_pkg::CSR_SLOPE_THR, 16'd256);
      random_frames(12);
      settle();
      csr_write(llsf_pkg::CSR_IMAGE_WIDTH, 16'($urandom_range(1, 4095)));
      csr_write(llsf_pkg::CSR_BOTTOM_ROW, 16'($urandom));
      csr_write(llsf_pkg::CSR_TOP_ROW, 16'($urandom));
      csr_write(llsf_pkg::CSR_SLOPE_THR, 16'($urandom_range(0, 1024)));
      random_frames(12);
      settle();
      csr_write(llsf_pkg::CSR_IMAGE_WIDTH, 16'd640);
      csr_write(llsf_pkg::CSR_BOTTOM_ROW, 16'd480);
      csr_write(llsf_pkg::CSR_TOP_ROW, 16'd288);
      csr_write(llsf_pkg::CSR_SLOPE_THR, 16'd128);
      random_frames(12);
      settle();

      if (mismatches == 0 && expected_fits.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

`default_nettype wire

### files.f
design/llsf_pkg.sv
design/llsf_if.sv
design/llsf_front.sv
design/llsf_queue.sv
design/llsf_arith.sv
design/llsf_back.sv
design/lane_line_least_squares_fit.sv
design/llsf_checker.sv
tb/lane_line_least_squares_fit_test.sv
